// File: design/efg_pkg.sv
// efg_pkg: shared types and codes for the event flag group block
// used by every module in design/
package efg_pkg;

	localparam int MAX_WAITERS_DEF = 8;
	localparam int FLAG_BITS_DEF   = 32;
	localparam int MASK_W          = 32;
	localparam int TASK_W          = 8;
	localparam int CNT_W           = 4;

	localparam logic [2:0] REQ_WAIT    = 3'd0;
	localparam logic [2:0] REQ_TRY     = 3'd1;
	localparam logic [2:0] REQ_NOTIFY  = 3'd2;
	localparam logic [2:0] REQ_QUERY   = 3'd3;
	localparam logic [2:0] REQ_DESTROY = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNAVAIL = 3'd1;
	localparam logic [2:0] ST_QUEUED  = 3'd2;
	localparam logic [2:0] ST_DELETED = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	// request as classified by the front end
	typedef struct packed {
		logic [2:0]        req;
		logic [2:0]        mode;
		logic [MASK_W-1:0] mask;
		logic              nset;
		logic [TASK_W-1:0] task_id;
	} req_t;

	// one result item
	typedef struct packed {
		logic [2:0]        status;
		logic [MASK_W-1:0] flags;
		logic [TASK_W-1:0] task_id;
		logic [CNT_W-1:0]  count;
		logic              last;
	} res_t;

endpackage

// File: design/event_flag_group_with_waiters.sv
// Event flag group with a table of waiting tasks.
// Requests enter through a queue port: push/full. An item is taken when push
// is high and full is low. A two-entry request queue sits in front of the
// executing back end, so requests can be pushed while the back end works.
// Results leave through empty/pop: the oldest result is on the ports while
// empty is low and is taken when pop is high. Every request yields one or more
// results; the final one has last set and all carry the waiter count left once
// the request is done.
// On an idle block a request goes through the request queue and the sequencer
// into the output register. A wait, try get, query or unknown request holds the
// back end until its single result is loaded. Notify walks the table one entry
// per cycle while cfg_valid is low, keeps the woken waiters in a small buffer and
// then hands out one result per cycle while the receiver pops them. Destroy hands
// out one result per waiter, or a single result with an empty table.
// A stalled receiver (pop low) holds the output register and the back end; the
// request queue keeps taking items until it fills.
// The cfg channel (cfg_valid/cfg_ready) loads the flag word and empties the
// table; it is meant for an idle block. Reset clears the flag word to zero and
// empties the table and both queues.
module event_flag_group_with_waiters #(
	parameter int MAX_WAITERS = efg_pkg::MAX_WAITERS_DEF,
	parameter int FLAG_BITS   = efg_pkg::FLAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  req_type,
	input  logic [2:0]  wait_mode,
	input  logic [31:0] request_mask,
	input  logic        notify_set,
	input  logic [7:0]  task_id,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [31:0] result_flags,
	output logic [7:0]  woken_task,
	output logic [3:0]  waiter_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	efg_pkg::req_t req_in, req_q;
	efg_pkg::res_t res;
	logic rq_valid, rq_take, res_valid;

	assign req_in = '{req: req_type, mode: wait_mode, mask: request_mask,
		nset: notify_set, task_id: task_id};
	assign cfg_ready = 1'b1;

	efg_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req_in(req_in),
		.req_valid(rq_valid), .req_take(rq_take), .req_out(req_q)
	);

	efg_back #(.MAX_WAITERS(MAX_WAITERS), .FLAG_BITS(FLAG_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_valid), .cfg_data(cfg_data),
		.req_valid(rq_valid), .req_take(rq_take), .req_in(req_q),
		.res_valid(res_valid), .res_take(pop), .res_out(res)
	);

	assign empty        = !res_valid;
	assign status       = res.status;
	assign result_flags = res.flags;
	assign woken_task   = res.task_id;
	assign waiter_count = res.count;
	assign last         = res.last;
endmodule

// File: design/efg_front.sv
// efg_front: accepts requests and holds them in a two-entry queue
// depends on efg_pkg
module efg_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  efg_pkg::req_t    req_in,
	output logic             req_valid,
	input  logic             req_take,
	output efg_pkg::req_t    req_out
);
	efg_pkg::req_t buf_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          do_push, do_pop;

	assign full      = (cnt_q == 2'd2);
	assign req_valid = (cnt_q != 2'd0);
	assign req_out   = buf_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = req_take && req_valid;

	always_ff @(posedge clk) begin
		if (do_push) buf_q[wp_q] <= req_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

// File: design/efg_back.sv
// efg_back: flag word, waiter table, wake buffer and the sequencer that walks them
// depends on efg_pkg
module efg_back #(
	parameter int MAX_WAITERS = efg_pkg::MAX_WAITERS_DEF,
	parameter int FLAG_BITS   = efg_pkg::FLAG_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [efg_pkg::MASK_W-1:0]  cfg_data,
	input  logic                        req_valid,
	output logic                        req_take,
	input  efg_pkg::req_t               req_in,
	output logic                        res_valid,
	input  logic                        res_take,
	output efg_pkg::res_t               res_out
);
	localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int NW = $clog2(MAX_WAITERS + 1);
	localparam logic [efg_pkg::MASK_W-1:0] LIM =
		(FLAG_BITS >= efg_pkg::MASK_W) ? {efg_pkg::MASK_W{1'b1}} :
		efg_pkg::MASK_W'((64'd1 << FLAG_BITS) - 64'd1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_WAKE = 3'd2;
	localparam logic [2:0] S_DEL  = 3'd3;
	localparam logic [2:0] S_ONE  = 3'd4;

	logic [2:0]                    state_q;
	logic [efg_pkg::MASK_W-1:0]    flag_q;
	logic [efg_pkg::TASK_W-1:0]    wtask_q [MAX_WAITERS];
	logic [efg_pkg::MASK_W-1:0]    wmask_q [MAX_WAITERS];
	logic [2:0]                    wmode_q [MAX_WAITERS];
	// woken waiters of a notify, handed out once the walk is over
	logic [efg_pkg::MASK_W-1:0]    kflags_q [MAX_WAITERS];
	logic [efg_pkg::TASK_W-1:0]    ktask_q [MAX_WAITERS];
	logic [NW-1:0]                 n_q;
	logic [NW-1:0]                 rd_q, wr_q, kn_q;
	efg_pkg::res_t                 one_q, one_d;
	efg_pkg::res_t                 res_q, res_d;
	logic                          rv_q;

	function automatic logic [efg_pkg::MASK_W:0] match_f(
		input logic [2:0] mode, input logic [efg_pkg::MASK_W-1:0] mask,
		input logic [efg_pkg::MASK_W-1:0] fw);
		logic [efg_pkg::MASK_W-1:0] m, hit;
		logic ok;
		m   = mask & LIM;
		hit = mode[0] ? (fw & m) : (~fw & m);
		ok  = mode[1] ? (hit == m) : (hit != '0);
		return {ok, hit};
	endfunction

	function automatic logic [efg_pkg::MASK_W-1:0] take_f(
		input logic [2:0] mode, input logic [efg_pkg::MASK_W-1:0] mask,
		input logic [efg_pkg::MASK_W-1:0] fw, input logic ok);
		logic [efg_pkg::MASK_W-1:0] m;
		m = mask & LIM;
		if (ok && mode[2]) return (mode[0] ? (fw & ~m) : (fw | m)) & LIM;
		return fw;
	endfunction

	logic [efg_pkg::MASK_W:0] mreq, mw;
	logic [IW-1:0] ri, wi, ki;
	logic [efg_pkg::MASK_W-1:0] nflag;
	logic tab_full, walk_end, out_free, load_res, emit_end;

	assign ri       = rd_q[IW-1:0];
	assign wi       = wr_q[IW-1:0];
	assign ki       = kn_q[IW-1:0];
	assign mreq     = match_f(req_in.mode, req_in.mask, flag_q);
	assign mw       = match_f(wmode_q[ri], wmask_q[ri], flag_q);
	assign tab_full = (n_q >= NW'(MAX_WAITERS));
	assign walk_end = (rd_q == n_q);
	assign out_free = !rv_q || res_take;
	assign req_take = (state_q == S_IDLE) && req_valid && !cfg_we;
	assign nflag = req_in.nset ? ((flag_q | req_in.mask) & LIM) : (flag_q & ~req_in.mask);

	assign res_valid = rv_q;
	assign res_out   = res_q;

	// single result of the request being accepted
	always_comb begin
		one_d = '{status: efg_pkg::ST_OK, flags: mreq[efg_pkg::MASK_W-1:0],
			task_id: req_in.task_id, count: efg_pkg::CNT_W'(n_q), last: 1'b1};
		unique case (req_in.req) inside
			efg_pkg::REQ_WAIT, efg_pkg::REQ_TRY: begin
				if (mreq[efg_pkg::MASK_W])
					one_d.status = efg_pkg::ST_OK;
				else if (req_in.req == efg_pkg::REQ_TRY)
					one_d.status = efg_pkg::ST_UNAVAIL;
				else if (tab_full)
					one_d.status = efg_pkg::ST_FULL;
				else begin
					one_d.status = efg_pkg::ST_QUEUED;
					one_d.count  = efg_pkg::CNT_W'(n_q + NW'(1));
				end
			end
			efg_pkg::REQ_QUERY: one_d.flags = flag_q;
			efg_pkg::REQ_NOTIFY, efg_pkg::REQ_DESTROY: one_d.flags = '0;
			default: begin
				one_d.status = efg_pkg::ST_UNAVAIL;
				one_d.flags  = '0;
			end
		endcase
	end

	// next value of the output register
	always_comb begin
		res_d    = one_q;
		load_res = 1'b0;
		emit_end = 1'b0;
		unique case (state_q) inside
			S_WAKE: begin
				load_res = out_free;
				emit_end = ((rd_q + NW'(1)) == kn_q);
				res_d = '{status: efg_pkg::ST_OK, flags: kflags_q[ri], task_id: ktask_q[ri],
					count: efg_pkg::CNT_W'(n_q), last: emit_end};
			end
			S_DEL: begin
				load_res = out_free;
				emit_end = ((rd_q + NW'(1)) == n_q);
				res_d = '{status: efg_pkg::ST_DELETED, flags: wmask_q[ri], task_id: wtask_q[ri],
					count: efg_pkg::CNT_W'(0), last: emit_end};
			end
			S_ONE: begin
				load_res = out_free;
				emit_end = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_take && (req_in.req == efg_pkg::REQ_WAIT) && !mreq[efg_pkg::MASK_W]
		    && !tab_full) begin
			wtask_q[n_q[IW-1:0]] <= req_in.task_id;
			wmask_q[n_q[IW-1:0]] <= req_in.mask;
			wmode_q[n_q[IW-1:0]] <= req_in.mode;
		end else if (state_q == S_WALK && !cfg_we && !walk_end) begin
			if (mw[efg_pkg::MASK_W]) begin
				kflags_q[ki] <= mw[efg_pkg::MASK_W-1:0];
				ktask_q[ki]  <= wtask_q[ri];
			end else begin
				// keep the table packed
				wtask_q[wi] <= wtask_q[ri];
				wmask_q[wi] <= wmask_q[ri];
				wmode_q[wi] <= wmode_q[ri];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			flag_q  <= '0;
			n_q     <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			kn_q    <= '0;
			one_q   <= '0;
			res_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (load_res) res_q <= res_d;
			rv_q <= load_res || (rv_q && !res_take);
			if (cfg_we) begin
				flag_q <= cfg_data & LIM;
				n_q    <= '0;
			end else begin
				unique case (state_q) inside
					S_IDLE: if (req_take) begin
						one_q <= one_d;
						rd_q  <= '0;
						wr_q  <= '0;
						kn_q  <= '0;
						unique case (req_in.req) inside
							efg_pkg::REQ_WAIT, efg_pkg::REQ_TRY: begin
								state_q <= S_ONE;
								if (mreq[efg_pkg::MASK_W])
									flag_q <= take_f(req_in.mode, req_in.mask, flag_q, 1'b1);
								else if (req_in.req == efg_pkg::REQ_WAIT && !tab_full)
									n_q <= n_q + NW'(1);
							end
							efg_pkg::REQ_NOTIFY: begin
								flag_q  <= nflag;
								state_q <= S_WALK;
							end
							efg_pkg::REQ_DESTROY: state_q <= (n_q == '0) ? S_ONE : S_DEL;
							default: state_q <= S_ONE;
						endcase
					end
					S_WALK: if (walk_end) begin
						n_q  <= wr_q;
						rd_q <= '0;
						if (kn_q == '0) begin
							// nobody woken: report the new flag word
							one_q.flags <= flag_q;
							one_q.count <= efg_pkg::CNT_W'(wr_q);
							state_q     <= S_ONE;
						end else begin
							state_q <= S_WAKE;
						end
					end else begin
						rd_q <= rd_q + NW'(1);
						if (mw[efg_pkg::MASK_W]) begin
							kn_q   <= kn_q + NW'(1);
							flag_q <= take_f(wmode_q[ri], wmask_q[ri], flag_q, 1'b1);
						end else begin
							wr_q <= wr_q + NW'(1);
						end
					end
					S_WAKE, S_DEL: if (load_res) begin
						rd_q <= rd_q + NW'(1);
						if (emit_end) begin
							state_q <= S_IDLE;
							if (state_q == S_DEL) n_q <= '0;
						end
					end
					S_ONE: if (load_res) state_q <= S_IDLE;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end
endmodule

// File: design/efg_checker.sv
// efg_checker: port-level assertions for the event flag group
// bound to event_flag_group_with_waiters; depends on efg_pkg
module efg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [2:0] status,
	input logic [3:0] waiter_count,
	input logic       last
);
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> waiter_count <= 4'd8) else $error("waiter count out of range");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status <= efg_pkg::ST_FULL) else $error("bad status");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(status)) else $error("result dropped");
	a_del: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == efg_pkg::ST_QUEUED |-> last) else $error("queued not last");
endmodule

bind event_flag_group_with_waiters efg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .status(status),
	.waiter_count(waiter_count), .last(last)
);

// File: sim/event_flag_group_with_waiters_tb.sv
// testbench for event_flag_group_with_waiters: directed and random requests
// checked against a behavioral model of the flag word and waiter table
// depends on efg_pkg and the block in design/
`timescale 1ns / 100ps

module event_flag_group_with_waiters_tb;

	localparam int WAITERS = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  req_type = '0;
	logic [2:0]  wait_mode = '0;
	logic [31:0] request_mask = '0;
	logic        notify_set = 1'b0;
	logic [7:0]  task_id = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  status;
	logic [31:0] result_flags;
	logic [7:0]  woken_task;
	logic [3:0]  waiter_count;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	event_flag_group_with_waiters dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .wait_mode(wait_mode), .request_mask(request_mask),
		.notify_set(notify_set), .task_id(task_id), .empty(empty), .pop(pop),
		.status(status), .result_flags(result_flags), .woken_task(woken_task),
		.waiter_count(waiter_count), .last(last), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// model state
	logic [31:0] flags_m;
	int          n_waiting;
	logic [7:0]  wt_task [WAITERS];
	logic [31:0] wt_mask [WAITERS];
	logic [2:0]  wt_mode [WAITERS];

	efg_pkg::res_t expected_q[$];
	int   errors = 0;
	int   idle_cycles = 0;
	bit   hold_pop = 0;
	int   hold_len = 0;
	int   pop_wait = 0;

	function automatic bit flag_match(input logic [2:0] mode, input logic [31:0] mask,
			output logic [31:0] hit);
		bit ok;
		hit = mode[0] ? (flags_m & mask) : (~flags_m & mask);
		ok = mode[1] ? (hit == mask) : (hit != 0);
		if (ok && mode[2])
			flags_m = mode[0] ? (flags_m & ~mask) : (flags_m | mask);
		return ok;
	endfunction

	task automatic predict_request(input efg_pkg::req_t r);
		efg_pkg::res_t out[$];
		efg_pkg::res_t x;
		logic [31:0] hit;
		int w;
		if (r.req == efg_pkg::REQ_WAIT || r.req == efg_pkg::REQ_TRY) begin
			x = '0; x.task_id = r.task_id;
			if (flag_match(r.mode, r.mask, hit)) x.status = efg_pkg::ST_OK;
			else if (r.req == efg_pkg::REQ_TRY) x.status = efg_pkg::ST_UNAVAIL;
			else if (n_waiting >= WAITERS) x.status = efg_pkg::ST_FULL;
			else begin
				wt_task[n_waiting] = r.task_id;
				wt_mask[n_waiting] = r.mask;
				wt_mode[n_waiting] = r.mode;
				n_waiting++;
				x.status = efg_pkg::ST_QUEUED;
			end
			x.flags = hit;
			out.push_back(x);
		end else if (r.req == efg_pkg::REQ_NOTIFY) begin
			flags_m = r.nset ? (flags_m | r.mask) : (flags_m & ~r.mask);
			w = 0;
			for (int i = 0; i < n_waiting; i++) begin
				if (flag_match(wt_mode[i], wt_mask[i], hit)) begin
					x = '0; x.status = efg_pkg::ST_OK; x.flags = hit; x.task_id = wt_task[i];
					out.push_back(x);
				end else begin
					wt_task[w] = wt_task[i]; wt_mask[w] = wt_mask[i]; wt_mode[w] = wt_mode[i];
					w++;
				end
			end
			n_waiting = w;
			if (out.size() == 0) begin
				x = '0; x.status = efg_pkg::ST_OK; x.flags = flags_m; x.task_id = r.task_id;
				out.push_back(x);
			end
		end else if (r.req == efg_pkg::REQ_QUERY) begin
			x = '0; x.status = efg_pkg::ST_OK; x.flags = flags_m; x.task_id = r.task_id;
			out.push_back(x);
		end else if (r.req == efg_pkg::REQ_DESTROY) begin
			for (int i = 0; i < n_waiting; i++) begin
				x = '0; x.status = efg_pkg::ST_DELETED; x.flags = wt_mask[i];
				x.task_id = wt_task[i];
				out.push_back(x);
			end
			n_waiting = 0;
			if (out.size() == 0) begin
				x = '0; x.status = efg_pkg::ST_OK; x.task_id = r.task_id;
				out.push_back(x);
			end
		end else begin
			x = '0; x.status = efg_pkg::ST_UNAVAIL; x.task_id = r.task_id;
			out.push_back(x);
		end
		foreach (out[i]) begin
			out[i].count = n_waiting[3:0];
			out[i].last = (i == out.size() - 1);
			expected_q.push_back(out[i]);
		end
	endtask

	// one transaction on the request side, with a random gap first
	task automatic send_request(input logic [2:0] rq, input logic [2:0] md,
			input logic [31:0] mk, input logic ns, input logic [7:0] tk);
		efg_pkg::req_t r;
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.req = rq; r.mode = md; r.mask = mk; r.nset = ns; r.task_id = tk;
		push <= 1'b1;
		req_type <= rq; wait_mode <= md; request_mask <= mk; notify_set <= ns; task_id <= tk;
		do @(posedge clk); while (full);
		predict_request(r);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_initial_flags(input logic [31:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		flags_m = v;
		n_waiting = 0;
		@(posedge clk);
	endtask

	// result side: a random wait before each result, long hold when requested
	always @(posedge clk) begin
		int w;
		w = 0;
		if (hold_len > 0) begin
			hold_len <= hold_len - 1;
			pop <= 1'b0;
		end else if (hold_pop) begin
			hold_len <= 300;
			hold_pop <= 0;
			pop <= 1'b0;
		end else if (pop_wait > 0) begin
			pop_wait <= pop_wait - 1;
			pop <= (pop_wait == 1);
		end else if (pop && !empty) begin
			w = $urandom_range(0, 11);
			pop_wait <= w;
			pop <= (w == 0);
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		efg_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result status=%0d flags=%h task=%0d", $time,
					status, result_flags, woken_task);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (status !== want.status) begin
					$display("%0t status exp %0d got %0d", $time, want.status, status);
					errors++;
				end
				if (result_flags !== want.flags) begin
					$display("%0t result_flags exp %h got %h", $time, want.flags, result_flags);
					errors++;
				end
				if (woken_task !== want.task_id) begin
					$display("%0t woken_task exp %0d got %0d", $time, want.task_id, woken_task);
					errors++;
				end
				if (waiter_count !== want.count) begin
					$display("%0t waiter_count exp %0d got %0d", $time, want.count, waiter_count);
					errors++;
				end
				if (last !== want.last) begin
					$display("%0t last exp %0d got %0d", $time, want.last, last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_directed();
		send_request(efg_pkg::REQ_QUERY, 3'd0, 32'h0, 1'b0, 8'd0);
		send_request(efg_pkg::REQ_TRY, 3'd1, 32'h1, 1'b0, 8'd255);
		send_request(efg_pkg::REQ_TRY, 3'd0, 32'h0, 1'b0, 8'd1);
		send_request(efg_pkg::REQ_WAIT, 3'd3, 32'h0, 1'b0, 8'd2);
		send_request(efg_pkg::REQ_DESTROY, 3'd0, 32'h0, 1'b0, 8'd3);
		for (int i = 0; i < 9; i++)
			send_request(efg_pkg::REQ_WAIT, 3'(i % 2 ? 3'd7 : 3'd5), 32'h1 << (i * 3), 1'b0,
				8'(10 + i));
		send_request(efg_pkg::REQ_NOTIFY, 3'd0, 32'hFFFF_FFFF, 1'b1, 8'd40);
		send_request(efg_pkg::REQ_WAIT, 3'd4, 32'hFFFF_FFFF, 1'b0, 8'd41);
		send_request(efg_pkg::REQ_WAIT, 3'd6, 32'h8000_0001, 1'b0, 8'd42);
		send_request(efg_pkg::REQ_NOTIFY, 3'd0, 32'hFFFF_FFFF, 1'b0, 8'd43);
		send_request(efg_pkg::REQ_NOTIFY, 3'd0, 32'h0, 1'b1, 8'd44);
		send_request(efg_pkg::REQ_DESTROY, 3'd0, 32'h0, 1'b0, 8'd45);
		// request types outside the defined set
		send_request(3'd5, 3'd7, 32'hAAAA_5555, 1'b1, 8'd46);
		send_request(3'd6, 3'd0, 32'h0, 1'b0, 8'd47);
		send_request(3'd7, 3'd0, 32'h0, 1'b0, 8'd48);
	endtask

	// random mix of mostly waits and notifies that wake subsets, with some noise
	task automatic test_random(input int count);
		logic [2:0] rq;
		logic [31:0] mk;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			mk = ($urandom_range(0, 3) == 0) ? $urandom : (32'h1 << $urandom_range(0, 31)) |
				(32'h1 << $urandom_range(0, 31));
			if (pick < 40) rq = efg_pkg::REQ_WAIT;
			else if (pick < 55) rq = efg_pkg::REQ_TRY;
			else if (pick < 80) rq = efg_pkg::REQ_NOTIFY;
			else if (pick < 88) rq = efg_pkg::REQ_QUERY;
			else if (pick < 95) rq = efg_pkg::REQ_DESTROY;
			else rq = 3'($urandom_range(5, 7));
			send_request(rq, 3'($urandom_range(0, 7)), mk, 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_backpressure();
		hold_pop = 1;
		@(posedge clk);
		for (int i = 0; i < 12; i++)
			send_request(efg_pkg::REQ_WAIT, 3'd1, 32'h1 << i, 1'b0, 8'(100 + i));
		drain_results();
		send_request(efg_pkg::REQ_NOTIFY, 3'd0, 32'hFFFF_FFFF, 1'b1, 8'd120);
		drain_results();
	endtask

	initial begin
		flags_m = '0;
		n_waiting = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_initial_flags(32'hFFFF_FFFF);
		test_directed();
		write_initial_flags(32'h0000_0000);
		test_backpressure();
		test_random(40);
		write_initial_flags($urandom);
		test_random(40);
		write_initial_flags(32'hA5A5_0F0F);
		test_random(30);
		drain_results();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
design/efg_pkg.sv
design/efg_front.sv
design/efg_back.sv
design/event_flag_group_with_waiters.sv
design/efg_checker.sv
sim/event_flag_group_with_waiters_tb.sv
